// ===== sv/tptt_pkg.sv =====
// tptt_pkg: types and constants for the touch point tracking table
// used by touch_point_tracking_table and its checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tptt_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int IdW        = 16;
  localparam int CoordW     = 12;
  localparam int MinDistW   = 13;
  localparam int SqW        = 2 * CoordW + 1;
  localparam int RootW      = CoordW + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_SQUARE,
    S_ROOT,
    S_WRITE,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== sv/touch_point_tracking_table.sv =====
// touch_point_tracking_table: table of active touch points held in a synchronous ram
// depends on tptt_pkg
//
// usage: raise start with op_i and its operands while busy is low; the block
// raises busy and later gives exactly one result on result_id_o / status_o,
// marked by a one-cycle done_o strobe. busy drops in the cycle after done_o.
// valid bits live in flip-flops and are scanned one slot per cycle, pausing
// at each valid slot for a ram read in update, delete and find, to find the
// lowest free slot, the lowest slot holding entry_id_i, or for find the
// nearest point closer than min_distance_i (ties go to the lower identifier).
// point data (identifier, x, y) lives in a ram with a registered read port.
// update and delete read each valid slot until one holds entry_id_i.
// find reads every valid slot, computes the squares and takes a bit-serial
// square root with RootW result bits to get its distance to the point.
// reset clears all valid bits and the identifier counter; the ram contents
// are left as they are. the receiver cannot stall: done_o marks each result
// for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module touch_point_tracking_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  output logic                               done_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [tptt_pkg::CoordW-1:0]   pos_x_i,
  input  wire logic [tptt_pkg::CoordW-1:0]   pos_y_i,
  input  wire logic [tptt_pkg::IdW-1:0]      entry_id_i,
  input  wire logic [tptt_pkg::MinDistW-1:0] min_distance_i,
  output logic [tptt_pkg::IdW-1:0]           result_id_o,
  output logic [1:0]                         status_o
);
  localparam int EntW = tptt_pkg::IdW + 2 * tptt_pkg::CoordW;
  localparam int CntW = $clog2(tptt_pkg::RootW + 1);

  tptt_pkg::state_e state_q, state_d;

  logic                            accept;
  logic [tptt_pkg::TableDepth-1:0] valid_q, valid_d;
  logic [tptt_pkg::IdW-1:0]        ctr_q, ctr_d;
  logic [tptt_pkg::IdxW:0]         idx_q, idx_d;
  logic [1:0]                      op_q;
  logic [tptt_pkg::CoordW-1:0]     px_q, py_q;
  logic [tptt_pkg::IdW-1:0]        eid_q;
  logic [tptt_pkg::MinDistW-1:0]   mind_q;
  logic [tptt_pkg::IdW-1:0]        rid_q, rid_d;
  logic [1:0]                      st_q, st_d;
  logic                            hit_q, hit_d;
  logic [tptt_pkg::RootW-1:0]      best_q, best_d;
  logic [tptt_pkg::IdW-1:0]        bid_q, bid_d;
  logic [tptt_pkg::IdW-1:0]        slot_id_q, slot_id_d;
  logic [tptt_pkg::SqW-1:0]        rem_q, rem_d;
  logic [tptt_pkg::RootW-1:0]      root_q, root_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            done_q, done_d;

  // ram
  logic [EntW-1:0] mem [tptt_pkg::TableDepth];
  logic [EntW-1:0] rdata_q;
  logic            we;
  logic [tptt_pkg::IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [tptt_pkg::IdW-1:0]    r_id;
  logic [tptt_pkg::CoordW-1:0] r_x, r_y, dx, dy;
  logic [tptt_pkg::IdxW-1:0]   idx;
  logic [tptt_pkg::IdW-1:0]    nid;
  logic [tptt_pkg::SqW+1:0]    trial;
  logic [2*tptt_pkg::RootW-1:0] trial_bit;

  assign accept = start && !busy;
  assign r_id = rdata_q[EntW-1 -: tptt_pkg::IdW];
  assign r_x  = rdata_q[2*tptt_pkg::CoordW-1 -: tptt_pkg::CoordW];
  assign r_y  = rdata_q[tptt_pkg::CoordW-1:0];
  assign dx   = (r_x >= px_q) ? r_x - px_q : px_q - r_x;
  assign dy   = (r_y >= py_q) ? r_y - py_q : py_q - r_y;
  assign idx  = idx_q[tptt_pkg::IdxW-1:0];
  assign nid  = (ctr_q + 1'b1 == '0) ? tptt_pkg::IdW'(1) : ctr_q + 1'b1;

  // restoring square root, one result bit per cycle
  always_comb begin
    trial_bit = '0;
    trial_bit[2*cnt_q] = 1'b1;
    trial = {2'b00, rem_q}
          - (tptt_pkg::SqW+2)'(({{tptt_pkg::RootW{1'b0}}, root_q} << (2 * cnt_q + 2)))
          - (tptt_pkg::SqW+2)'(trial_bit);
  end

  always_comb begin
    state_d = state_q; valid_d = valid_q; ctr_d = ctr_q; idx_d = idx_q;
    rid_d = rid_q; st_d = st_q; hit_d = hit_q; best_d = best_q; bid_d = bid_q;
    slot_id_d = slot_id_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q;
    done_d = 1'b0; we = 1'b0; waddr = idx; raddr = idx;
    wdata = {nid, px_q, py_q};
    case (state_q)
      tptt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = tptt_pkg::S_SCAN; idx_d = '0; hit_d = 1'b0; bid_d = '0;
          best_d = '1;
        end
      end
      tptt_pkg::S_SCAN: begin
        if (idx_q == (tptt_pkg::IdxW+1)'(tptt_pkg::TableDepth)) begin
          rid_d = '0;
          if (op_q == tptt_pkg::OP_FIND) begin
            st_d = hit_q ? tptt_pkg::ST_OK : tptt_pkg::ST_NOT_FOUND;
            rid_d = hit_q ? bid_q : '0;
          end else if (op_q == tptt_pkg::OP_INSERT) st_d = tptt_pkg::ST_FULL;
          else st_d = tptt_pkg::ST_NOT_FOUND;
          state_d = tptt_pkg::S_DONE;
        end else if (op_q == tptt_pkg::OP_INSERT) begin
          if (!valid_q[idx]) begin
            we = 1'b1; valid_d[idx] = 1'b1; ctr_d = nid;
            rid_d = nid; st_d = tptt_pkg::ST_OK; state_d = tptt_pkg::S_DONE;
          end else idx_d = idx_q + 1'b1;
        end else if (valid_q[idx]) state_d = tptt_pkg::S_READ;
        else idx_d = idx_q + 1'b1;
      end
      tptt_pkg::S_READ: begin
        // rdata_q now holds the slot
        slot_id_d = r_id;
        if (op_q == tptt_pkg::OP_FIND) state_d = tptt_pkg::S_SQUARE;
        else if (r_id == eid_q) state_d = tptt_pkg::S_WRITE;
        else begin idx_d = idx_q + 1'b1; state_d = tptt_pkg::S_SCAN; end
      end
      tptt_pkg::S_SQUARE: begin
        rem_d = tptt_pkg::SqW'(dx) * tptt_pkg::SqW'(dx)
              + tptt_pkg::SqW'(dy) * tptt_pkg::SqW'(dy);
        root_d = '0; cnt_d = CntW'(tptt_pkg::RootW - 1);
        state_d = tptt_pkg::S_ROOT;
      end
      tptt_pkg::S_ROOT: begin
        if (!trial[tptt_pkg::SqW+1]) begin
          rem_d = trial[tptt_pkg::SqW-1:0];
          root_d = {root_q[tptt_pkg::RootW-2:0], 1'b1};
        end else root_d = {root_q[tptt_pkg::RootW-2:0], 1'b0};
        if (cnt_q == '0) begin
          if ((tptt_pkg::MinDistW)'(root_d) < mind_q &&
              (!hit_q || root_d < best_q || (root_d == best_q && slot_id_q < bid_q))) begin
            hit_d = 1'b1; best_d = root_d; bid_d = slot_id_q;
          end
          idx_d = idx_q + 1'b1; state_d = tptt_pkg::S_SCAN;
        end else cnt_d = cnt_q - 1'b1;
      end
      tptt_pkg::S_WRITE: begin
        if (op_q == tptt_pkg::OP_DELETE) valid_d[idx] = 1'b0;
        else begin we = 1'b1; wdata = {slot_id_q, px_q, py_q}; end
        rid_d = '0; st_d = tptt_pkg::ST_OK; state_d = tptt_pkg::S_DONE;
      end
      tptt_pkg::S_DONE: begin
        done_d = 1'b1; state_d = tptt_pkg::S_IDLE;
      end
      default: state_d = tptt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tptt_pkg::S_IDLE; valid_q <= '0; ctr_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; valid_q <= valid_d; ctr_q <= ctr_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; rid_q <= rid_d; st_q <= st_d; hit_q <= hit_d;
    best_q <= best_d; bid_q <= bid_d; slot_id_q <= slot_id_d;
    rem_q <= rem_d; root_q <= root_d; cnt_q <= cnt_d;
    if (state_q == tptt_pkg::S_IDLE && accept) begin
      op_q <= op_i; px_q <= pos_x_i; py_q <= pos_y_i; eid_q <= entry_id_i;
      mind_q <= min_distance_i;
    end
  end

  assign busy        = (state_q != tptt_pkg::S_IDLE) || done_q;
  assign done_o      = done_q;
  assign result_id_o = rid_q;
  assign status_o    = st_q;
endmodule
`default_nettype wire

// ===== sv/tptt_checker.sv =====
// tptt_checker: port-level assertions for touch_point_tracking_table
// depends on tptt_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none
module tptt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [1:0] status_o,
  input wire logic [tptt_pkg::IdW-1:0] result_id_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept without busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != tptt_pkg::ST_OK |-> result_id_o == '0)
    else $error("nonzero id on failure");
endmodule

bind touch_point_tracking_table tptt_checker u_tptt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .status_o(status_o), .result_id_o(result_id_o)
);
`default_nettype wire
